### rtl/assert_macros.svh
// Assertion macros shared by the window mean history RTL.
// Files that check their own logic include this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WMH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WMH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wmh_pkg.sv
// Package for the window mean history block: field widths, command codes
// and the request and result payload types. No dependencies.
`timescale 1ns / 1ps

package wmh_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int CMD_W       = 2;
	localparam int LOOK_W      = 6;
	localparam int COUNT_W     = 7;
	localparam int WIN_REG_W   = 7;
	localparam int DEPTH_DEF   = 64;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef logic [WIN_REG_W-1:0] cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0]              cmd;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [LOOK_W-1:0]             lookback;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0]            count;
		logic signed [SAMPLE_BITS-1:0] window_mean;
		logic signed [SAMPLE_BITS-1:0] read_value;
		logic                          index_error;
	} result_t;

endpackage

### rtl/wmh_chan_if.sv
// Valid/ready channel interface used for every port of the block.
// The payload type is a parameter; the block uses the types of wmh_pkg.
`timescale 1ns / 1ps

interface wmh_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/window_mean_history.sv
// Top level of the window mean history block: request and result channels,
// the control sequence and the history state. Uses wmh_pkg, wmh_chan_if,
// wmh_store and wmh_div.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Keeps the last window_size samples (Q16.16) in a ring held in one
// synchronous memory and reports, for every request, the held count and the
// mean of the running sum over window_size, truncated toward zero. A request
// is a push, a read of the sample lookback steps behind the newest, or a
// clear; any other command only reports. One request is worked at a time.
// Its result is loaded after these steps: the memory read data arrives and
// the ring, count and sum are updated, the bit-serial divider forms the
// mean, the divider flags that it is done, and the result register is
// loaded. The request side is ready again in the cycle after that load, so
// a new request is taken only once the previous result is loaded. The
// result register frees the request side, so the next request is taken even
// if the result has not been taken yet; only the load of the following
// result waits for it.
// Writing window_size also clears the history; write it only while no
// request is in flight. A value of zero acts as one and a value above DEPTH
// acts as DEPTH. No clearing pass is needed after reset: slots at or beyond
// the held count read as zero.
module window_mean_history #(
	parameter int DEPTH = wmh_pkg::DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wmh_chan_if.sink   cfg,
	wmh_chan_if.sink   item,
	wmh_chan_if.source result
);
	import wmh_pkg::*;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
	localparam int IW     = ((CNT_W > LOOK_W) ? CNT_W : LOOK_W) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// Control and history state.
	logic [1:0]             state_q;
	logic [WIN_REG_W-1:0]   window_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [CNT_W-1:0]       count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                   res_valid_q;
	result_t                res_q;

	// Request captured at acceptance.
	logic [CMD_W-1:0]       cmd_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   err_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [SAMPLE_BITS-1:0] rdval_q;

	logic [CNT_W-1:0]       win_eff;
	logic                   item_acc;
	logic                   cfg_acc;
	logic                   full;
	logic [CNT_W-1:0]       pos_inc;
	logic [ADDR_W-1:0]      pos_nxt;
	logic [IW-1:0]          slot_diff;
	logic [IW-1:0]          slot_wrap;
	logic                   look_err;
	logic [ADDR_W-1:0]      rd_addr;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic signed [SUM_W-1:0] old_ext;
	logic signed [SUM_W-1:0] new_ext;
	logic signed [SUM_W-1:0] sum_nxt;
	logic                   wr_en;
	logic                   div_start;
	logic                   div_done;
	logic [SAMPLE_BITS-1:0] mean;
	logic                   load_res;

	// Window actually in use: zero acts as one, anything above the ring as
	// the ring depth.
	always_comb begin
		if (window_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (int'(window_q) > DEPTH) begin
			win_eff = CNT_W'(DEPTH);
		end else begin
			win_eff = CNT_W'(window_q);
		end
	end

	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_acc   = item.valid & item.ready;
	assign cfg_acc    = cfg.valid & cfg.ready;
	assign full       = (count_q == win_eff);

	// A push moves the newest position only when the ring already holds
	// something, wrapping at the window.
	always_comb begin
		pos_inc = CNT_W'(pos_q) + CNT_W'(1);
		if (count_q == '0) begin
			pos_nxt = pos_q;
		end else if (pos_inc >= win_eff) begin
			pos_nxt = '0;
		end else begin
			pos_nxt = ADDR_W'(pos_inc);
		end
	end

	// Read slot: newest position minus lookback, modulo the window.
	always_comb begin
		look_err  = IW'(item.data.lookback) >= IW'(win_eff);
		slot_diff = IW'(pos_q) - IW'(item.data.lookback);
		slot_wrap = slot_diff[IW-1] ? slot_diff + IW'(win_eff) : slot_diff;
	end

	assign rd_addr = (item.data.cmd == CMD_READ) ? ADDR_W'(slot_wrap) : pos_nxt;

	// The push overwrites a slot; its old value leaves the running sum only
	// when the window is full, since only then was that slot filled.
	assign old_ext = {{(SUM_W - SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
	assign new_ext = {{(SUM_W - SAMPLE_BITS){sample_s1[SAMPLE_BITS-1]}}, sample_s1};

	always_comb begin
		unique case (cmd_s1)
			CMD_PUSH: begin
				sum_nxt = sum_q - (full ? old_ext : '0) + new_ext;
			end
			CMD_CLEAR: begin
				sum_nxt = '0;
			end
			default: begin
				sum_nxt = sum_q;
			end
		endcase
	end

	assign wr_en     = (state_q == ST_MOD) && (cmd_s1 == CMD_PUSH);
	assign div_start = (state_q == ST_MOD);
	assign load_res  = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	wmh_store #(
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (sample_s1),
		.rd_en   (item_acc),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	wmh_div #(
		.SUM_W (SUM_W),
		.DIV_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nxt),
		.divisor  (win_eff),
		.done     (div_done),
		.quotient (mean)
	);

	// Sequencer and history state. A configuration write clears the history;
	// the user must send it only while no request is in flight (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			window_q <= WIN_REG_W'(DEPTH_DEF);
			pos_q    <= '0;
			count_q  <= '0;
			sum_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_DIV;
					sum_q   <= sum_nxt;
					unique case (cmd_s1)
						CMD_PUSH: begin
							pos_q <= addr_s1;
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						CMD_CLEAR: begin
							pos_q   <= '0;
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_acc) begin
				window_q <= cfg.data;
				pos_q    <= '0;
				count_q  <= '0;
				sum_q    <= '0;
			end
		end
	end

	// Request fields and read result; no reset needed.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			cmd_s1    <= item.data.cmd;
			sample_s1 <= item.data.sample;
			err_s1    <= (item.data.cmd == CMD_READ) && look_err;
			addr_s1   <= rd_addr;
		end
		if (state_q == ST_MOD) begin
			// Slots at or past the held count were not written since the
			// last clear and read as zero.
			if (cmd_s1 == CMD_READ && !err_s1 && CNT_W'(addr_s1) < count_q) begin
				rdval_q <= rd_data;
			end else begin
				rdval_q <= '0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.count       <= COUNT_W'(count_q);
			res_q.window_mean <= mean;
			res_q.read_value  <= rdval_q;
			res_q.index_error <= err_s1;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	`WMH_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= win_eff, "count above window")
	`WMH_ASSERT_NOW(a_pos_bound, clk, arst_n, 1'b1, CNT_W'(pos_q) < win_eff, "position outside window")
	`WMH_ASSERT_NEXT(a_acc_mod, clk, arst_n, item_acc, state_q == ST_MOD, "accepted request not worked")

endmodule

### rtl/wmh_store.sv
// Sample store: one synchronous memory, one write port and one read port
// with registered read data. Depends on wmh_pkg for the sample width.
`timescale 1ns / 1ps

module wmh_store #(
	parameter int DEPTH = wmh_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(DEPTH)-1:0]            wr_addr,
	input  logic [wmh_pkg::SAMPLE_BITS-1:0]     wr_data,
	input  logic                                rd_en,
	input  logic [$clog2(DEPTH)-1:0]            rd_addr,
	output logic [wmh_pkg::SAMPLE_BITS-1:0]     rd_data
);
	import wmh_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/wmh_div.sv
// Bit-serial restoring divider: signed running sum over the unsigned
// window, truncated toward zero, one quotient bit per cycle. Uses wmh_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wmh_div #(
	parameter int SUM_W = 38,
	parameter int DIV_W = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [SUM_W-1:0]             dividend,
	input  logic [DIV_W-1:0]                    divisor,
	output logic                                done,
	output logic [wmh_pkg::SAMPLE_BITS-1:0]     quotient
);
	import wmh_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic              busy_q;
	logic              done_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [SUM_W-1:0]  quo_q;

	logic [SUM_W-1:0]  mag;
	logic [DIV_W:0]    shifted;
	logic [DIV_W+1:0]  diff;
	logic              qbit;

	assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign qbit    = ~diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], qbit};
			rem_q <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? SAMPLE_BITS'(-quo_q[SAMPLE_BITS-1:0])
	                        : quo_q[SAMPLE_BITS-1:0];

	`WMH_ASSERT_NOW(a_start_idle, clk, arst_n, start, !busy_q, "divider started while busy")
	`WMH_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q, "divider did not start")
	`WMH_ASSERT_NOW(a_rem_bound, clk, arst_n, busy_q, rem_q < dvs_q, "remainder not below divisor")

endmodule

### test/window_mean_history_test.sv
// Self-checking test of window_mean_history: an in-bench ring and running-sum predictor
// checks each result. Needs wmh_pkg, wmh_chan_if and the block with its submodules.
`timescale 1ns / 1ps

module window_mean_history_test;
	import wmh_pkg::*;

	// The package names no code for the fourth command; the block must only report on it.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RING_SLOTS  = DEPTH_DEF;
	localparam int PHASE_ITEMS = 200;
	localparam int PHASES      = 9;
	localparam int MAX_LINES   = 40;

	// Scoreboard: keeps its own copy of the ring, the newest position, the held count,
	// the 38-bit running sum and the window register. Each accepted request is worked
	// through at once and its result is queued until the block hands it back.
	class mean_history_board;
		logic signed [SAMPLE_BITS-1:0] ring[RING_SLOTS];
		logic [LOOK_W-1:0]             newest;
		logic [COUNT_W-1:0]            held;
		logic signed [37:0]            total;
		cfg_t                          win_reg;
		result_t                       awaited_results[$];
		int                            errors;

		function new();
			errors = 0;
			win_reg = cfg_t'(RING_SLOTS);
			wipe();
		endfunction

		function void wipe();
			foreach (ring[i])
				ring[i] = '0;
			newest = '0;
			held = '0;
			total = '0;
		endfunction

		function int unsigned span();
			if (win_reg == 0)
				return 1;
			if (win_reg > RING_SLOTS)
				return RING_SLOTS;
			return win_reg;
		endfunction

		function void set_window(cfg_t v);
			win_reg = v;
			wipe();
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		function void note_request(item_t req);
			int unsigned w;
			int unsigned slot;
			longint      quot;
			result_t     want;
			w = span();
			want = '0;
			if (newest >= w)
				newest = '0;
			if (held > w)
				held = COUNT_W'(w);
			case (req.cmd)
				CMD_PUSH: begin
					// The newest position stays put for the first sample after empty.
					if (held > 0)
						newest = (newest + 1 >= w) ? '0 : newest + 1'b1;
					if (held >= w)
						total = total - ring[newest];
					else
						held = held + 1'b1;
					ring[newest] = req.sample;
					total = total + req.sample;
				end
				CMD_READ: begin
					if (req.lookback >= w) begin
						want.index_error = 1'b1;
					end else begin
						slot = (newest >= req.lookback) ? newest - req.lookback
							: newest + w - req.lookback;
						want.read_value = ring[LOOK_W'(slot % RING_SLOTS)];
					end
				end
				CMD_CLEAR: begin
					wipe();
				end
				default: begin
				end
			endcase
			quot = longint'(total) / longint'(w);
			want.count = held;
			want.window_mean = quot[SAMPLE_BITS-1:0];
			awaited_results.push_back(want);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_LINES)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(result_t got);
			result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result with none awaited, count %0d", got.count));
				return;
			end
			want = awaited_results.pop_front();
			if (got.count !== want.count)
				report($sformatf("count %0d, want %0d", got.count, want.count));
			if (got.window_mean !== want.window_mean)
				report($sformatf("window_mean %h, want %h", got.window_mean, want.window_mean));
			if (got.read_value !== want.read_value)
				report($sformatf("read_value %h, want %h", got.read_value, want.read_value));
			if (got.index_error !== want.index_error)
				report($sformatf("index_error %b, want %b", got.index_error, want.index_error));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	wmh_chan_if #(.payload_t(cfg_t))    cfg_ch ();
	wmh_chan_if #(.payload_t(item_t))   item_ch ();
	wmh_chan_if #(.payload_t(result_t)) res_ch ();

	window_mean_history u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	mean_history_board board;

	// Idling controls shared by the request and result sides. In the calm stretch at
	// the end neither side idles, so back-to-back requests are seen as well.
	bit calm;
	int gap_pct;
	int stall_pct;

	always #5 clk = ~clk;

	// Every result accepted at an edge is checked against the oldest awaited one.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid && res_ch.ready)
			board.check_result(res_ch.data);
	end

	// Result side: ready comes and goes in bursts, with stalls between them.
	initial begin : result_sink
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 99) < stall_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	function automatic item_t make_request(logic [CMD_W-1:0] cmd, logic [31:0] sample,
			logic [LOOK_W-1:0] lookback);
		item_t req;
		req.cmd = cmd;
		req.sample = sample;
		req.lookback = lookback;
		return req;
	endfunction

	// Random request. Pushes and in-window reads dominate so the ring fills and wraps;
	// clears stay rare so even a 64-slot window saturates between them. Samples mix full
	// random words, the two extremes and small values around zero.
	function automatic item_t random_request(int unsigned w);
		int               pick;
		logic [31:0]      value;
		logic [LOOK_W-1:0] look;
		logic [CMD_W-1:0] cmd;
		pick = $urandom_range(0, 99);
		if (pick < 52)
			cmd = CMD_PUSH;
		else if (pick < 95)
			cmd = CMD_READ;
		else if (pick < 96)
			cmd = CMD_CLEAR;
		else
			cmd = CMD_UNUSED;
		case ($urandom_range(0, 9))
			0: value = 32'h7fff_ffff;
			1: value = 32'h8000_0000;
			2: value = 32'($urandom_range(0, 131071)) - 32'd65536;
			default: value = $urandom;
		endcase
		if ($urandom_range(0, 3) != 0)
			look = LOOK_W'($urandom_range(0, w - 1));
		else
			look = LOOK_W'($urandom_range(0, 63));
		return make_request(cmd, value, look);
	endfunction

	// Offers one request and waits until the block takes it. Valid stays high when
	// the next request follows directly; it is lowered only for a gap or by drain.
	task automatic send_request(item_t req);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= req;
		do
			@(posedge clk);
		while (!item_ch.ready);
		board.note_request(req);
	endtask

	// Stops offering requests and waits until every awaited result has come back.
	// Each request yields exactly one result, so the block is idle after that.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_window(cfg_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.set_window(v);
	endtask

	initial begin : stimulus
		item_t directed[$];
		cfg_t  win;
		board = new();
		calm = 1'b0;
		gap_pct = 30;
		stall_pct = 30;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset window of 64: a read of the empty history, the first push not
		// moving the newest position, both sample extremes, a read reaching back past
		// the held samples into zeroed slots, the unused command and a clear.
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd0));
		directed.push_back(make_request(CMD_PUSH, 32'h7fff_ffff, 6'd0));
		directed.push_back(make_request(CMD_PUSH, 32'h8000_0000, 6'd63));
		directed.push_back(make_request(CMD_PUSH, 32'h0001_8000, 6'd0));
		directed.push_back(make_request(CMD_READ, 32'hffff_ffff, 6'd0));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd2));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd63));
		directed.push_back(make_request(CMD_UNUSED, 32'hffff_ffff, 6'd63));
		directed.push_back(make_request(CMD_PUSH, 32'hffff_ffff, 6'd0));
		directed.push_back(make_request(CMD_CLEAR, 32'h0, 6'd0));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd1));
		foreach (directed[i])
			send_request(directed[i]);
		drain();

		// Directed, window of 3: wrap of the ring, overwrite with the oldest sample
		// dropped from the sum, out-of-range lookbacks and a read after a clear.
		write_window(cfg_t'(3));
		directed.delete();
		directed.push_back(make_request(CMD_PUSH, 32'h0001_0000, 6'd0));
		directed.push_back(make_request(CMD_PUSH, 32'h0002_0000, 6'd0));
		directed.push_back(make_request(CMD_PUSH, 32'h0003_0000, 6'd0));
		directed.push_back(make_request(CMD_PUSH, 32'hfffc_0000, 6'd0));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd0));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd2));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd3));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd63));
		directed.push_back(make_request(CMD_UNUSED, 32'h0, 6'd1));
		directed.push_back(make_request(CMD_CLEAR, 32'h0, 6'd0));
		directed.push_back(make_request(CMD_READ, 32'h0, 6'd1));
		directed.push_back(make_request(CMD_PUSH, 32'hffff_ffff, 6'd0));
		foreach (directed[i])
			send_request(directed[i]);

		// Random phases, each under its own window setting: the one-slot window, zero
		// (acts as one), the largest register value and 65 (both act as 64), small, full and
		// random sizes. Idling varies by phase, and the last phase has none at all.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: win = cfg_t'(1);
				1: win = cfg_t'(0);
				2: win = cfg_t'(127);
				3: win = cfg_t'(2);
				4: win = cfg_t'(64);
				5: win = cfg_t'(65);
				6, 7: win = cfg_t'($urandom_range(1, 64));
				default: win = cfg_t'(64);
			endcase
			write_window(win);
			gap_pct = (p % 3) * 30;
			stall_pct = ((p + 1) % 3) * 30;
			calm = (p == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_request(board.span()));
		end

		drain();
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// A run that hangs is ended here as a failure.
	initial begin : watchdog
		#8000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/wmh_pkg.sv
rtl/wmh_chan_if.sv
rtl/wmh_store.sv
rtl/wmh_div.sv
rtl/window_mean_history.sv
test/window_mean_history_test.sv
